@@ src/stq_pkg.sv @@
// ----------------------------------------------------------------------------
// stq_pkg
// Shared constants, types and helpers for the sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int DEPTH     = 16;
  localparam int TIME_BITS = 48;
  localparam int ID_BITS   = 8;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_EXPIRE = 1'b1;

  typedef struct packed {
    logic [TIME_BITS-1:0] tm;
    logic [ID_BITS-1:0]   id;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_EXP_RD,
    ST_EXP_CMP,
    ST_OUT
  } state_t;

  // Logical slot -> physical address in the circular store.
  function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] head,
                                                 input logic [IDX_W-1:0] slot);
    logic [IDX_W:0] s;
    s = {1'b0, head} + {1'b0, slot};
    if (s >= (IDX_W+1)'(DEPTH)) begin
      s = s - (IDX_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

@@ src/stq_req_if.sv @@
// ----------------------------------------------------------------------------
// stq_req_if
// Request channel: insert or expire items.
// ----------------------------------------------------------------------------
interface stq_req_if;
  import stq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [TIME_BITS-1:0] expiry_time;
  logic [ID_BITS-1:0]   timer_id;
  logic [TIME_BITS-1:0] now_time;

  modport source (output valid, kind, expiry_time, timer_id, now_time, input ready);
  modport sink   (input valid, kind, expiry_time, timer_id, now_time, output ready);
endinterface

@@ src/stq_rsp_if.sv @@
// ----------------------------------------------------------------------------
// stq_rsp_if
// Response channel: insert status and expired timers.
// ----------------------------------------------------------------------------
interface stq_rsp_if;
  import stq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 earliest_changed;
  logic                 queue_full;
  logic                 has_entry;
  logic [ID_BITS-1:0]   expired_id;
  logic [TIME_BITS-1:0] expired_time;
  logic                 last;

  modport source (output valid, earliest_changed, queue_full, has_entry, expired_id,
                  expired_time, last, input ready);
  modport sink   (input valid, earliest_changed, queue_full, has_entry, expired_id,
                  expired_time, last, output ready);
endinterface

@@ src/sorted_timer_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Pending timers kept sorted by (time, id) in a circular store.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one transfer per item. kind=0 inserts (expiry_time, timer_id);
//          kind=1 expires every timer with time <= now_time.
//   rsp  : insert -> one transfer (earliest_changed / queue_full, last=1).
//          expire -> one transfer per expired timer in order, last on the
//          final one; nothing due -> one transfer with has_entry=0, last=1.
// Sequencing:
//   One item is worked at a time; req.ready is high only when idle, which
//   is the cycle after the final result is loaded.
//   Insert walks from the tail toward the head, a read step and then a
//   compare and write-back step per entry that moves; a refused insert
//   goes straight to the output state.
//   Expire pops from the head, a read step and then a compare step per
//   popped timer.
//   The store has one read and one write port with registered read data,
//   which is why each compare step follows a read step.
// Reset: clears state, count, head and rsp.valid; store contents are
//   left undefined and never read before being written.
// Stall: a held rsp transfer freezes the walk at the next emit point; the
//   output register keeps the result until taken.
// ----------------------------------------------------------------------------
module sorted_timer_queue (
  input  logic      clk,
  input  logic      rst,
  stq_req_if.sink   req,
  stq_rsp_if.source rsp
);
  import stq_pkg::*;

  state_t state, state_next;

  entry_t mem [DEPTH];
  entry_t rd_q;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  logic [IDX_W-1:0]     head;
  logic [CNT_W-1:0]     count;
  logic [IDX_W-1:0]     slot;       // insert: candidate slot for the new timer
  logic [TIME_BITS-1:0] front_time; // time of the head entry
  entry_t               item;       // latched insert timer
  logic [TIME_BITS-1:0] now_q;
  logic                 chg_q;
  logic                 full_q;
  entry_t               pend;       // popped timer waiting for its last flag
  logic                 pend_valid;

  logic out_free;
  logic rd_gt;
  logic due;
  logic accept;
  logic rsp_load;   // output register takes a new result this cycle

  assign out_free = !rsp.valid || rsp.ready;
  assign accept   = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);

  assign rd_gt = (rd_q.tm > item.tm) || (rd_q.tm == item.tm && rd_q.id > item.id);
  assign due   = (count != '0) && (rd_q.tm <= now_q);

  assign rsp_load = ((state == ST_EXP_CMP) && due && pend_valid && out_free) ||
                    ((state == ST_OUT) && out_free);

  // Store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.kind == KIND_EXPIRE) begin
            state_next = ST_EXP_RD;
          end else if (count == CNT_W'(DEPTH)) begin
            state_next = ST_OUT;
          end else begin
            state_next = ST_INS_RD;
          end
        end
      end
      ST_INS_RD:  state_next = (slot == '0) ? ST_OUT : ST_INS_CMP;
      ST_INS_CMP: state_next = rd_gt ? ST_INS_RD : ST_OUT;
      ST_EXP_RD:  state_next = ST_EXP_CMP;
      ST_EXP_CMP: begin
        if (!due) begin
          state_next = ST_OUT;
        end else if (!pend_valid || out_free) begin
          state_next = ST_EXP_RD;
        end
      end
      ST_OUT:     state_next = out_free ? ST_IDLE : ST_OUT;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Store control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head;
    wr_en   = 1'b0;
    wr_addr = phys_addr(head, slot);
    wr_data = item;
    case (state)
      ST_INS_RD: begin
        if (slot == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = phys_addr(head, slot - 1'b1);
        end
      end
      ST_INS_CMP: begin
        wr_en = 1'b1;
        if (rd_gt) begin
          wr_data = rd_q;
        end
      end
      ST_EXP_RD: rd_en = (count != '0);
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      count      <= '0;
      pend_valid <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: pend_valid <= 1'b0;
        ST_INS_RD: begin
          if (slot == '0) begin
            count <= count + 1'b1;
          end
        end
        ST_INS_CMP: begin
          if (!rd_gt) begin
            count <= count + 1'b1;
          end
        end
        ST_EXP_CMP: begin
          if (due && (!pend_valid || out_free)) begin
            pend_valid <= 1'b1;
            head       <= phys_addr(head, IDX_W'(1));
            count      <= count - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          item.tm <= req.expiry_time;
          item.id <= req.timer_id;
          now_q   <= req.now_time;
          slot    <= count[IDX_W-1:0];
          full_q  <= (req.kind == KIND_INSERT) && (count == CNT_W'(DEPTH));
          chg_q   <= (req.kind == KIND_INSERT) && (count != CNT_W'(DEPTH)) &&
                     ((count == '0) || (req.expiry_time < front_time));
          pend    <= '0;
        end
      end
      ST_INS_RD: begin
        if (slot == '0) begin
          front_time <= item.tm;
        end
      end
      ST_INS_CMP: begin
        if (rd_gt) begin
          slot <= slot - 1'b1;
        end
      end
      ST_EXP_CMP: begin
        if (due && (!pend_valid || out_free)) begin
          pend <= rd_q;
          if (pend_valid) begin
            rsp.earliest_changed <= 1'b0;
            rsp.queue_full       <= 1'b0;
            rsp.has_entry        <= 1'b1;
            rsp.expired_id       <= pend.id;
            rsp.expired_time     <= pend.tm;
            rsp.last             <= 1'b0;
          end
        end else if (!due && count != '0) begin
          front_time <= rd_q.tm;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          rsp.earliest_changed <= chg_q;
          rsp.queue_full       <= full_q;
          rsp.has_entry        <= pend_valid;
          rsp.expired_id       <= pend.id;
          rsp.expired_time     <= pend.tm;
          rsp.last             <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ src/stq_check.sv @@
// ----------------------------------------------------------------------------
// stq_check
// Port-level checks for the sorted timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module stq_check (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic earliest_changed,
  input logic queue_full,
  input logic has_entry,
  input logic last
);

  // A refused insert reports nothing else.
  a_full_alone: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && queue_full |-> !earliest_changed && !has_entry && last)
    else $error("queue_full with other flags");

  // An empty expire result closes its item.
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !has_entry |-> last)
    else $error("empty result without last");

  // Insert status never comes with an expired timer.
  a_chg_no_entry: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && earliest_changed |-> !has_entry)
    else $error("earliest_changed with entry");

  // Stalled transfer stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp valid dropped");

endmodule

bind sorted_timer_queue stq_check u_stq_check (
  .clk              (clk),
  .rst              (rst),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .earliest_changed (rsp.earliest_changed),
  .queue_full       (rsp.queue_full),
  .has_entry        (rsp.has_entry),
  .last             (rsp.last)
);
